/* src/unique_key_compacting_list_assert.svh */
// Assertion macros used by the unique-key list top level.
`ifndef UNIQUE_KEY_COMPACTING_LIST_ASSERT_SVH
`define UNIQUE_KEY_COMPACTING_LIST_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define UKCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define UKCL_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define UKCL_ASSERT(label, prop, msg)
`define UKCL_ASSERT_RST(label, prop, msg)
`endif

`endif

/* src/ukcl_pkg.sv */
// Types and constants of the unique-key compacting list.
package ukcl_pkg;

  localparam int unsigned KeyW    = 16;
  localparam int unsigned PayW    = 32;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 7;
  localparam int unsigned CountW  = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_DUP     = 2'd2,
    STAT_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY
  } state_e;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic live;   // cell holds an entry
    logic load;   // take the request key and payload
    logic shift;  // take the neighbor above
  } cell_ctrl_t;

endpackage

/* src/ukcl_cell.sv */
// One list slot: key and payload storage with a key comparator.
module ukcl_cell
  import ukcl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic [KeyW-1:0] req_key_i,
  input  logic [PayW-1:0] req_pay_i,
  input  logic [KeyW-1:0] nbr_key_i,
  input  logic [PayW-1:0] nbr_pay_i,
  output logic [KeyW-1:0] key_o,
  output logic [PayW-1:0] pay_o,
  output logic            hit_o
);

  logic [KeyW-1:0] key_q, key_d;
  logic [PayW-1:0] pay_q, pay_d;
  logic            hit_q, hit_d;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctrl_i.load) begin
      key_d = req_key_i;
      pay_d = req_pay_i;
    end else if (ctrl_i.shift) begin
      key_d = nbr_key_i;
      pay_d = nbr_pay_i;
    end
    hit_d = ctrl_i.live && (key_q == req_key_i);
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign key_o = key_q;
  assign pay_o = pay_q;
  assign hit_o = hit_q;

endmodule

/* src/unique_key_compacting_list.sv */
// Top level: bounded unique-key list kept in insertion order, on a chain of cells.
//
// Usage
//   Commands enter on the s_axis channel: tuser carries the command (insert,
//   delete, lookup; code 3 acts as lookup), tdata the key and the payload.
//   Every command gives exactly one result beat on m_axis: tuser carries the
//   status, tdata the found payload, found position and entry count.
// Sequencing
//   An accepted command passes the match state, where all cells compare
//   their key against the request and register the hit, and then the apply
//   state, where insert or delete is applied and the result registered. A
//   new command is taken only when idle or in the apply state of the last.
//   Deletion closes the gap in that same apply state: every cell at or above
//   the matching one takes the entry of its upper neighbor.
// Reset
//   Asynchronous, active low. The entry count goes to zero; the stored keys
//   and payloads are not cleared and are never read while not live.
// Backpressure
//   The result sits in an output register. A new command is taken while a
//   result waits; if the next result is ready while the previous one is
//   still not taken, the block holds in its apply cycle until it is.
`include "unique_key_compacting_list_assert.svh"

module unique_key_compacting_list
  import ukcl_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] entry_key, [47:16] entry_payload
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] found_payload, [38:32] found_position, [46:39] entry_count, [47] zero
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned Lv   = $clog2(CAPACITY);

  state_e state_q, state_d;

  // Request registers
  logic [CmdW-1:0] cmd_q;
  logic [KeyW-1:0] key_q;
  logic [PayW-1:0] pay_q;

  logic [CntW-1:0] count_q, count_d;

  // Output register
  logic               m_valid_q, m_valid_d;
  logic [StatusW-1:0] o_status_q, o_status_d;
  logic [PayW-1:0]    o_pay_q, o_pay_d;
  logic [PosW-1:0]    o_pos_q, o_pos_d;
  logic [CountW-1:0]  o_cnt_q, o_cnt_d;

  logic out_free, s_fire, apply_fire;
  logic is_insert, is_delete, full, any_hit;
  logic ins_ok, del_ok;

  // Cell chain wiring
  cell_ctrl_t              ctrl   [CAPACITY];
  logic [KeyW-1:0]         c_key  [CAPACITY];
  logic [PayW-1:0]         c_pay  [CAPACITY];
  logic [CAPACITY-1:0]     hit;
  logic [CAPACITY-1:0]     pre [Lv+1];
  logic [PosW-1:0]         hit_pos;
  logic [PayW-1:0]         hit_pay;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) || ((state_q == ST_APPLY) && out_free);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign apply_fire    = (state_q == ST_APPLY) && out_free;

  assign is_insert = (cmd_q == CMD_INSERT);
  assign is_delete = (cmd_q == CMD_DELETE);
  assign full      = (count_q >= CntW'(CAPACITY));
  assign any_hit   = |hit;
  assign ins_ok    = apply_fire && is_insert && !full && !any_hit;
  assign del_ok    = apply_fire && is_delete && any_hit;

  // Prefix OR of hit: cells at or above the match shift down on delete.
  always_comb begin
    pre[0] = hit;
    for (int l = 0; l < Lv; l++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
  end

  // Match is one-hot at most: OR-combine position and payload.
  always_comb begin
    hit_pos = '0;
    hit_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        hit_pos = hit_pos | PosW'(i);
        hit_pay = hit_pay | c_pay[i];
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KeyW-1:0] nbr_key;
    logic [PayW-1:0] nbr_pay;

    if (i == CAPACITY - 1) begin : g_top
      assign nbr_key       = c_key[i];
      assign nbr_pay       = c_pay[i];
      assign ctrl[i].shift = 1'b0;
    end else begin : g_mid
      assign nbr_key       = c_key[i+1];
      assign nbr_pay       = c_pay[i+1];
      assign ctrl[i].shift = del_ok && pre[Lv][i];
    end

    assign ctrl[i].live = (CntW'(i) < count_q);
    assign ctrl[i].load = ins_ok && (count_q == CntW'(i));

    ukcl_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[i]),
      .req_key_i (key_q),
      .req_pay_i (pay_q),
      .nbr_key_i (nbr_key),
      .nbr_pay_i (nbr_pay),
      .key_o     (c_key[i]),
      .pay_o     (c_pay[i]),
      .hit_o     (hit[i])
    );
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) state_d = ST_MATCH;
      end
      ST_MATCH: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) state_d = s_axis_tvalid ? ST_MATCH : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Count and result
  always_comb begin
    count_d = count_q;
    if (ins_ok) count_d = count_q + 1'b1;
    else if (del_ok) count_d = count_q - 1'b1;

    o_status_d = STAT_OK;
    o_pay_d    = '0;
    o_pos_d    = '0;
    case (cmd_q)
      CMD_INSERT: begin
        if (full) o_status_d = STAT_FULL;
        else if (any_hit) o_status_d = STAT_DUP;
      end
      CMD_DELETE: begin
        if (!any_hit) o_status_d = STAT_MISSING;
      end
      default: begin
        if (!any_hit) begin
          o_status_d = STAT_MISSING;
        end else begin
          o_pay_d = hit_pay;
          o_pos_d = hit_pos;
        end
      end
    endcase
    o_cnt_d = CountW'(count_d);

    m_valid_d = m_valid_q;
    if (apply_fire) m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q <= s_axis_tuser;
      key_q <= s_axis_tdata[KeyW-1:0];
      pay_q <= s_axis_tdata[KeyW+PayW-1:KeyW];
    end
    if (apply_fire) begin
      o_status_q <= o_status_d;
      o_pay_q    <= o_pay_d;
      o_pos_q    <= o_pos_d;
      o_cnt_q    <= o_cnt_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = o_status_q;
  assign m_axis_tdata  = {1'b0, o_cnt_q, o_pos_q, o_pay_q};

  // Keys of live cells are unique, so at most one cell matches.
  `UKCL_ASSERT(a_hit_onehot, $onehot0(hit), "more than one cell matched the key")
  `UKCL_ASSERT(a_count_bound, count_q <= CntW'(CAPACITY), "entry count above capacity")
  `UKCL_ASSERT(a_ins_count, ins_ok |=> count_q == $past(count_q) + 1'b1,
               "insert did not raise the count")
  `UKCL_ASSERT(a_del_count, del_ok |=> count_q == $past(count_q) - 1'b1,
               "delete did not lower the count")
  `UKCL_ASSERT(a_stall_hold, (state_q == ST_APPLY && !out_free) |=> state_q == ST_APPLY,
               "apply left while the result register was busy")
  `UKCL_ASSERT_RST(a_rst_count, !rst_ni |-> count_q == '0, "count not cleared in reset")

endmodule

/* tb/unique_key_compacting_list_test.sv */
// Self-checking testbench for the unique-key compacting list.
module unique_key_compacting_list_test;
  import ukcl_pkg::*;

  localparam int unsigned LIST_DEPTH     = 128;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned TIMEOUT_CYCLES = 200_000;
  // Unused command code, decoded by the block as a lookup.
  localparam logic [CmdW-1:0] CMD_SPARE  = 2'd3;

  typedef struct packed {
    status_e           status;
    logic [PayW-1:0]   payload;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] count;
  } list_reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Shadow copy of the list contents.
  logic [KeyW-1:0] list_keys [LIST_DEPTH];
  logic [PayW-1:0] list_pays [LIST_DEPTH];
  int unsigned     list_fill;

  list_reply_t pending_replies [$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned rx_hold_left;

  unique_key_compacting_list #(
    .CAPACITY(LIST_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("DONE: errors detected");
    $finish;
  end

  // Position of a live key, -1 when absent.
  function automatic int locate_key(logic [KeyW-1:0] key);
    for (int i = 0; i < int'(list_fill); i++) begin
      if (list_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow list and return the reply it must give.
  function automatic list_reply_t apply_command(logic [CmdW-1:0] cmd, logic [KeyW-1:0] key,
                                                logic [PayW-1:0] pay);
    list_reply_t reply;
    int          at;
    reply = '0;
    reply.status = STAT_OK;
    at = locate_key(key);
    case (cmd)
      CMD_INSERT: begin
        // full wins over duplicate
        if (list_fill >= LIST_DEPTH) begin
          reply.status = STAT_FULL;
        end else if (at >= 0) begin
          reply.status = STAT_DUP;
        end else begin
          list_keys[list_fill] = key;
          list_pays[list_fill] = pay;
          list_fill++;
        end
      end
      CMD_DELETE: begin
        if (at < 0) begin
          reply.status = STAT_MISSING;
        end else begin
          for (int i = at; i + 1 < int'(list_fill); i++) begin
            list_keys[i] = list_keys[i+1];
            list_pays[i] = list_pays[i+1];
          end
          list_fill--;
        end
      end
      default: begin
        // lookup and the spare code
        if (at < 0) begin
          reply.status = STAT_MISSING;
        end else begin
          reply.payload  = list_pays[at];
          reply.position = PosW'(at);
        end
      end
    endcase
    reply.count = CountW'(list_fill);
    return reply;
  endfunction

  // Random key, biased toward keys already in the list.
  function automatic logic [KeyW-1:0] pick_key();
    if (list_fill > 0 && $urandom_range(99, 0) < 60) return list_keys[$urandom_range(list_fill-1, 0)];
    return KeyW'($urandom());
  endfunction

  // Offer one command beat; record its reply once accepted.
  task automatic send_command(logic [CmdW-1:0] cmd, logic [KeyW-1:0] key, logic [PayW-1:0] pay);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pay, key};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_replies.push_back(apply_command(cmd, key, pay));
  endtask

  // Stop offering and wait until every reply is back.
  task automatic wait_for_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_replies.size() != 0);
  endtask

  task automatic test_directed();
    send_command(CMD_LOOKUP, 16'h0000, 32'h0000_0000);  // empty list
    send_command(CMD_DELETE, 16'hFFFF, 32'hFFFF_FFFF);  // delete of absent key
    send_command(CMD_INSERT, 16'h0000, 32'h0000_0000);
    send_command(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 16'h1234, 32'hA5A5_A5A5);
    send_command(CMD_INSERT, 16'hFFFF, 32'h5A5A_5A5A);  // duplicate
    send_command(CMD_LOOKUP, 16'hFFFF, 32'h0000_0000);
    send_command(CMD_SPARE,  16'h1234, 32'hFFFF_FFFF);  // spare code acts as lookup
    send_command(CMD_LOOKUP, 16'h5555, 32'h0000_0000);  // lookup of absent key
    send_command(CMD_DELETE, 16'h0000, 32'h0000_0000);  // head, rest shifts down
    send_command(CMD_LOOKUP, 16'h1234, 32'h0000_0000);
    send_command(CMD_INSERT, 16'h8000, 32'h8000_0000);
    send_command(CMD_DELETE, 16'h1234, 32'h0000_0000);  // middle
    send_command(CMD_DELETE, 16'h8000, 32'h0000_0000);  // tail
    send_command(CMD_LOOKUP, 16'hFFFF, 32'h0000_0000);
    send_command(CMD_DELETE, 16'hFFFF, 32'h0000_0000);  // list empty again
    send_command(CMD_DELETE, 16'hFFFF, 32'h0000_0000);
    send_command(CMD_SPARE,  16'h0001, 32'h0000_0000);  // spare code, absent key
    wait_for_replies();
  endtask

  // Fill to capacity while the receiver holds off, then poke the full list.
  task automatic test_fill_to_capacity();
    logic [KeyW-1:0] key;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold_left   = RX_HOLD_CYCLES;
    while (list_fill < LIST_DEPTH) begin
      do key = KeyW'($urandom()); while (locate_key(key) >= 0);
      send_command(CMD_INSERT, key, $urandom());
    end
    do key = KeyW'($urandom()); while (locate_key(key) >= 0);
    send_command(CMD_INSERT, key, $urandom());               // full
    send_command(CMD_INSERT, list_keys[5], $urandom());      // full and duplicate
    send_command(CMD_LOOKUP, list_keys[LIST_DEPTH-1], $urandom());
    send_command(CMD_LOOKUP, list_keys[0], $urandom());
    send_command(CMD_DELETE, list_keys[LIST_DEPTH/2], $urandom());
    send_command(CMD_LOOKUP, list_keys[LIST_DEPTH-2], $urandom());
    send_command(CMD_INSERT, key, $urandom());
    wait_for_replies();
  endtask

  task automatic test_random_mix(int unsigned idle_pct, int unsigned stall_pct, int unsigned beats);
    int unsigned roll;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (beats) begin
      roll = $urandom_range(99, 0);
      if (roll < 45)      send_command(CMD_INSERT, pick_key(), $urandom());
      else if (roll < 70) send_command(CMD_DELETE, pick_key(), $urandom());
      else if (roll < 95) send_command(CMD_LOOKUP, pick_key(), $urandom());
      else                send_command(CMD_SPARE,  pick_key(), $urandom());
    end
    wait_for_replies();
  endtask

  // Empty the list in random order, with the odd miss and lookup.
  task automatic test_drain();
    int unsigned roll;
    while (list_fill > 0) begin
      roll = $urandom_range(9, 0);
      if (roll == 0)      send_command(CMD_DELETE, KeyW'($urandom()), $urandom());
      else if (roll == 1) send_command(CMD_LOOKUP, pick_key(), $urandom());
      else send_command(CMD_DELETE, list_keys[$urandom_range(list_fill-1, 0)], $urandom());
    end
    wait_for_replies();
  endtask

  // Receiver: random stalls, plus a long hold when one is requested.
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left  = rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, expected, actual);
    end
  endtask

  // Reply checker: each result beat against the oldest pending reply.
  always @(posedge clk_i) begin
    list_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat, expected none, actual 0x%0h/0x%0h", $time,
                 m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tuser));
        check_field("found_payload", want.payload, m_axis_tdata[31:0]);
        check_field("found_position", 32'(want.position), 32'(m_axis_tdata[38:32]));
        check_field("entry_count", 32'(want.count), 32'(m_axis_tdata[46:39]));
      end
    end
  end

  initial begin
    error_count    = 0;
    list_fill      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold_left   = 0;
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= '0;
    m_axis_tready  <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix(27, 47, 180);
    test_fill_to_capacity();
    test_random_mix(47, 27, 180);
    test_drain();
    test_random_mix(0, 0, 180);

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/ukcl_pkg.sv
src/ukcl_cell.sv
src/unique_key_compacting_list.sv
tb/unique_key_compacting_list_test.sv
